FILE: design/ipf_pkg.sv
// ----------------------------------------------------------------------------
// ipf_pkg
// Shared constants and types of the IPv4 prefix filter.
// ----------------------------------------------------------------------------
package ipf_pkg;

  localparam int RULE_SLOTS = 256;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [31:0] LOOPBACK_ADDR  = 32'h7F00_0001;
  localparam logic [7:0]  IPP_ICMP       = 8'd1;
  localparam logic [7:0]  IPP_TCP        = 8'd6;
  localparam logic [7:0]  IPP_UDP        = 8'd17;
  localparam logic [5:0]  MAX_PLEN       = 6'd32;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] REASON_PASS   = 2'd0;
  localparam logic [1:0] REASON_DROP   = 2'd1;
  localparam logic [1:0] REASON_NON_IP = 2'd2;

  typedef struct packed {
    logic        valid;
    logic [31:0] prefix;
    logic [5:0]  plen;
    logic [7:0]  proto;
    logic [15:0] port;
  } rule_t;

  typedef struct packed {
    logic        valid;
    logic        found;
    logic [5:0]  plen;
    logic [7:0]  proto;
    logic [15:0] port;
  } match_t;

endpackage

FILE: design/ipf_if.sv
// ----------------------------------------------------------------------------
// ipf_req_if / ipf_rsp_if
// Request and response channels of the IPv4 prefix filter.
// ----------------------------------------------------------------------------
interface ipf_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [7:0]  rule_slot;
  logic        rule_valid;
  logic [31:0] rule_prefix;
  logic [5:0]  rule_prefix_len;
  logic [7:0]  rule_protocol;
  logic [15:0] rule_dport;

  modport source (output valid, operation, data_byte, last_byte, rule_slot, rule_valid,
                  rule_prefix, rule_prefix_len, rule_protocol, rule_dport, input ready);
  modport sink (input valid, operation, data_byte, last_byte, rule_slot, rule_valid,
                rule_prefix, rule_prefix_len, rule_protocol, rule_dport, output ready);
endinterface

interface ipf_rsp_if;
  logic        valid;
  logic        ready;
  logic        verdict;
  logic [1:0]  reason;
  logic [63:0] pass_total;
  logic [63:0] drop_total;
  logic [63:0] non_ip_total;

  modport source (output valid, verdict, reason, pass_total, drop_total, non_ip_total,
                  input ready);
  modport sink (input valid, verdict, reason, pass_total, drop_total, non_ip_total,
                output ready);
endinterface

FILE: design/ipv4_lpm_packet_filter.sv
// ----------------------------------------------------------------------------
// ipv4_lpm_packet_filter
// IPv4 longest-prefix-match packet filter with running verdict counters.
// ----------------------------------------------------------------------------
// Frame bytes and rule writes are taken one per cycle on req while req is
// ready. After the last byte of a frame, a match token walks the chain of
// RULE_SLOTS rule cells, one cell per cycle, and req stalls until the verdict
// is registered on rsp. The stall is longer while an earlier verdict still
// waits on rsp. The next frame may start while a verdict still waits on rsp.
module ipv4_lpm_packet_filter (
  input logic      clk,
  input logic      rst,
  ipf_req_if.sink  req,
  ipf_rsp_if.source rsp
);

  localparam int N = ipf_pkg::RULE_SLOTS;

  typedef enum logic [1:0] {COLLECT, START, SEARCH, DONE} state_t;

  state_t          state;
  logic [5:0]      byte_position;
  logic [6:0]      frame_len;
  logic [15:0]     ether_type;
  logic [7:0]      ip_protocol;
  logic [31:0]     source_address;
  logic [31:0]     dest_address;
  logic [15:0]     dest_port_capture;
  ipf_pkg::match_t best;
  ipf_pkg::match_t link [0:N];
  ipf_pkg::rule_t  wr_rule;
  logic            wr_go;

  logic            out_valid;
  logic            out_verdict;
  logic [1:0]      out_reason;
  logic [63:0]     pass_total;
  logic [63:0]     drop_total;
  logic [63:0]     non_ip_total;

  logic            accept;
  logic [7:0]      proto_map;
  logic [15:0]     l4_port;
  logic [1:0]      reason_next;
  logic            load;

  assign req.ready = (state == COLLECT);
  assign accept    = req.valid && req.ready;
  assign wr_go     = accept && (req.operation == ipf_pkg::OP_WRITE) && (byte_position == 6'd0);

  assign wr_rule.valid  = req.rule_valid;
  assign wr_rule.prefix = req.rule_prefix;
  assign wr_rule.plen   = req.rule_prefix_len;
  assign wr_rule.proto  = req.rule_protocol;
  assign wr_rule.port   = req.rule_dport;

  always_comb begin
    link[0]       = '0;
    link[0].valid = (state == START);
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    ipf_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr_en   (wr_go && (32'(req.rule_slot) == i)),
      .wr_rule (wr_rule),
      .dest    (dest_address),
      .din     (link[i]),
      .dout    (link[i+1])
    );
  end

  always_comb begin
    if (ip_protocol == ipf_pkg::IPP_TCP || ip_protocol == ipf_pkg::IPP_UDP ||
        ip_protocol == ipf_pkg::IPP_ICMP) begin
      proto_map = ip_protocol;
    end else begin
      proto_map = 8'd0;
    end
    if ((proto_map == ipf_pkg::IPP_TCP || proto_map == ipf_pkg::IPP_UDP) &&
        frame_len >= 7'd38) begin
      l4_port = dest_port_capture;
    end else begin
      l4_port = 16'd0;
    end
    if (frame_len < 7'd14 || ether_type != ipf_pkg::ETHERTYPE_IPV4) begin
      reason_next = ipf_pkg::REASON_NON_IP;
    end else if (frame_len < 7'd34) begin
      reason_next = ipf_pkg::REASON_DROP;
    end else if (source_address == ipf_pkg::LOOPBACK_ADDR ||
                 dest_address == ipf_pkg::LOOPBACK_ADDR) begin
      reason_next = ipf_pkg::REASON_PASS;
    end else if (best.found && (best.proto == 8'd0 || best.proto == proto_map) &&
                 (best.port == 16'd0 || best.port == l4_port)) begin
      reason_next = ipf_pkg::REASON_PASS;
    end else begin
      reason_next = ipf_pkg::REASON_DROP;
    end
    load = (state == DONE) && (!out_valid || rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= COLLECT;
      byte_position     <= 6'd0;
      frame_len         <= 7'd0;
      ether_type        <= 16'd0;
      ip_protocol       <= 8'd0;
      source_address    <= 32'd0;
      dest_address      <= 32'd0;
      dest_port_capture <= 16'd0;
      out_valid         <= 1'b0;
      pass_total        <= 64'd0;
      drop_total        <= 64'd0;
      non_ip_total      <= 64'd0;
    end else begin
      if (out_valid && rsp.ready && !load) begin
        out_valid <= 1'b0;
      end
      case (state)
        COLLECT: begin
          if (accept && req.operation == ipf_pkg::OP_BYTE) begin
            case (byte_position)
              6'd12: ether_type[15:8] <= req.data_byte;
              6'd13: ether_type[7:0] <= req.data_byte;
              6'd23: ip_protocol <= req.data_byte;
              6'd26, 6'd27, 6'd28, 6'd29:
                source_address <= {source_address[23:0], req.data_byte};
              6'd30, 6'd31, 6'd32, 6'd33:
                dest_address <= {dest_address[23:0], req.data_byte};
              6'd36: dest_port_capture[15:8] <= req.data_byte;
              6'd37: dest_port_capture[7:0] <= req.data_byte;
              default: ;
            endcase
            if (req.last_byte) begin
              frame_len <= {1'b0, byte_position} + 7'd1;
              state     <= START;
            end else if (byte_position != 6'd63) begin
              byte_position <= byte_position + 6'd1;
            end
          end
        end
        START: begin
          state <= SEARCH;
        end
        SEARCH: begin
          if (link[N].valid) begin
            best  <= link[N];
            state <= DONE;
          end
        end
        DONE: begin
          if (load) begin
            out_valid   <= 1'b1;
            out_verdict <= (reason_next != ipf_pkg::REASON_DROP);
            out_reason  <= reason_next;
            case (reason_next)
              ipf_pkg::REASON_PASS:   pass_total <= pass_total + 64'd1;
              ipf_pkg::REASON_DROP:   drop_total <= drop_total + 64'd1;
              default:                non_ip_total <= non_ip_total + 64'd1;
            endcase
            byte_position     <= 6'd0;
            ether_type        <= 16'd0;
            ip_protocol       <= 8'd0;
            source_address    <= 32'd0;
            dest_address      <= 32'd0;
            dest_port_capture <= 16'd0;
            state             <= COLLECT;
          end
        end
        default: state <= COLLECT;
      endcase
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.verdict      = out_verdict;
  assign rsp.reason       = out_reason;
  assign rsp.pass_total   = pass_total;
  assign rsp.drop_total   = drop_total;
  assign rsp.non_ip_total = non_ip_total;

endmodule

FILE: design/ipf_cell.sv
// ----------------------------------------------------------------------------
// ipf_cell
// One rule slot: holds its rule and updates the best match passing through.
// ----------------------------------------------------------------------------
module ipf_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  ipf_pkg::rule_t wr_rule,
  input  logic [31:0]    dest,
  input  ipf_pkg::match_t din,
  output ipf_pkg::match_t dout
);

  ipf_pkg::rule_t rule;
  logic [31:0]    mask;
  logic           hit;
  logic           take;

  always_comb begin
    mask = ~(32'hFFFF_FFFF >> rule.plen);
    hit  = rule.valid && (((rule.prefix ^ dest) & mask) == 32'd0);
    take = hit && (!din.found || (rule.plen > din.plen));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rule.valid <= 1'b0;
    end else if (wr_en) begin
      rule.valid <= wr_rule.valid;
    end
    if (wr_en) begin
      rule.prefix <= wr_rule.prefix;
      rule.plen   <= (wr_rule.plen > ipf_pkg::MAX_PLEN) ? ipf_pkg::MAX_PLEN : wr_rule.plen;
      rule.proto  <= wr_rule.proto;
      rule.port   <= wr_rule.port;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    if (take) begin
      dout.found <= 1'b1;
      dout.plen  <= rule.plen;
      dout.proto <= rule.proto;
      dout.port  <= rule.port;
    end else begin
      dout.found <= din.found;
      dout.plen  <= din.plen;
      dout.proto <= din.proto;
      dout.port  <= din.port;
    end
  end

endmodule

FILE: design/ipf_checker.sv
// ----------------------------------------------------------------------------
// ipf_checker
// Port-level checks of the IPv4 prefix filter, bound to the top level.
// ----------------------------------------------------------------------------
module ipf_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        verdict,
  input logic [1:0]  reason,
  input logic [63:0] pass_total,
  input logic [63:0] drop_total,
  input logic [63:0] non_ip_total
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(pass_total) && $stable(drop_total) &&
    $stable(non_ip_total))
    else $error("stalled response changed");

  a_verdict: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (verdict == (reason != ipf_pkg::REASON_DROP)))
    else $error("verdict disagrees with reason");

  a_reason: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (reason == ipf_pkg::REASON_PASS || reason == ipf_pkg::REASON_DROP ||
                   reason == ipf_pkg::REASON_NON_IP))
    else $error("bad reason code");

  a_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready ##1 rsp_valid |->
    (pass_total + drop_total + non_ip_total) ==
    ($past(pass_total) + $past(drop_total) + $past(non_ip_total) + 64'd1))
    else $error("counters did not advance by one");

  a_release: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $rose(req_ready))
    else $error("verdict appeared without releasing the request channel");

endmodule

bind ipv4_lpm_packet_filter ipf_checker u_ipf_checker (
  .clk          (clk),
  .rst          (rst),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .verdict      (rsp.verdict),
  .reason       (rsp.reason),
  .pass_total   (rsp.pass_total),
  .drop_total   (rsp.drop_total),
  .non_ip_total (rsp.non_ip_total)
);
